>>> hw/rtl/wgm_pkg.sv
`default_nettype none
package wgm_pkg;

  localparam int PATTERN_CHARS_DEF = 16;
  localparam int CHAR_BITS_DEF     = 16;

  localparam int STORED_CHARS      = 16;
  localparam int PAT_WORDS         = 4;
  localparam int PAT_CHAR_W        = 16;
  localparam int CHARS_PER_WORD    = 4;

  localparam int TEXT_W            = 16;
  localparam int OUT_W             = 8;
  localparam int LEN_W             = 5;

  localparam int CFG_DATA_W        = 64;
  localparam int CFG_ADDR_W        = 6;
  localparam int CFG_IDX_LSB       = 3;
  localparam int CFG_IDX_W         = CFG_ADDR_W - CFG_IDX_LSB;

  localparam logic [7:0] ANY_ONE   = 8'h3F;
  localparam logic [7:0] ANY_RUN   = 8'h2A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_LEN  = 3'd4
  } reg_idx_t;

endpackage
`default_nettype wire

>>> hw/rtl/wgm_cfg.sv
`default_nettype none
module wgm_cfg #(
  parameter int PATTERN_CHARS = wgm_pkg::PATTERN_CHARS_DEF,
  parameter int CHAR_BITS     = wgm_pkg::CHAR_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [wgm_pkg::CFG_ADDR_W-1:0]          paddr,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]          pwdata,
  output logic [wgm_pkg::CFG_DATA_W-1:0]          prdata,
  output logic [PATTERN_CHARS-1:0][CHAR_BITS-1:0] chars,
  output logic [PATTERN_CHARS-1:0]                en_mask,
  output logic [PATTERN_CHARS-1:0]                star_mask,
  output logic [wgm_pkg::LEN_W-1:0]               len_eff,
  output logic                                    rearm
);
  import wgm_pkg::*;

  localparam int USE_CHARS = (PATTERN_CHARS < STORED_CHARS) ? PATTERN_CHARS : STORED_CHARS;

  logic [CFG_DATA_W-1:0] pat_word_r [PAT_WORDS];
  logic [LEN_W-1:0]      plen_r;
  reg_idx_t              idx;
  logic                  wr_en;
  logic                  hit;

  assign idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    hit    = 1'b1;
    prdata = '0;
    unique case (idx)
      REG_PAT0: prdata = pat_word_r[0];
      REG_PAT1: prdata = pat_word_r[1];
      REG_PAT2: prdata = pat_word_r[2];
      REG_PAT3: prdata = pat_word_r[3];
      REG_LEN:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, plen_r};
      default:  hit = 1'b0;
    endcase
  end

  assign rearm = wr_en && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < PAT_WORDS; w++) pat_word_r[w] <= '0;
      plen_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PAT0: pat_word_r[0] <= pwdata;
        REG_PAT1: pat_word_r[1] <= pwdata;
        REG_PAT2: pat_word_r[2] <= pwdata;
        REG_PAT3: pat_word_r[3] <= pwdata;
        REG_LEN:  plen_r        <= pwdata[LEN_W-1:0];
        default:  ;
      endcase
    end
  end

  assign len_eff = (plen_r > LEN_W'(USE_CHARS)) ? LEN_W'(USE_CHARS) : plen_r;

  for (genvar gi = 0; gi < PATTERN_CHARS; gi++) begin : g_pos
    if (gi < STORED_CHARS) begin : g_stored
      assign chars[gi] =
        pat_word_r[gi / CHARS_PER_WORD][(gi % CHARS_PER_WORD) * PAT_CHAR_W +: CHAR_BITS];
    end else begin : g_empty
      assign chars[gi] = '0;
    end
    assign en_mask[gi]   = LEN_W'(gi) < len_eff;
    assign star_mask[gi] = en_mask[gi] && (chars[gi] == CHAR_BITS'(ANY_RUN));
  end

endmodule
`default_nettype wire

>>> hw/rtl/wgm_front.sv
`default_nettype none
module wgm_front #(
  parameter int PATTERN_CHARS = wgm_pkg::PATTERN_CHARS_DEF,
  parameter int CHAR_BITS     = wgm_pkg::CHAR_BITS_DEF
) (
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [wgm_pkg::TEXT_W-1:0]              text_char,
  input  logic                                    end_of_text,
  input  logic [PATTERN_CHARS-1:0][CHAR_BITS-1:0] chars,
  input  logic [PATTERN_CHARS-1:0]                en_mask,
  input  logic [PATTERN_CHARS-1:0]                star_mask,
  input  logic                                    q_full,
  output logic                                    q_push,
  output logic [PATTERN_CHARS:0]                  q_wdata
);
  import wgm_pkg::*;

  logic [CHAR_BITS-1:0]     c;
  logic [PATTERN_CHARS-1:0] adv;

  assign c = text_char[CHAR_BITS-1:0];

  always_comb begin
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      adv[i] = en_mask[i] && !star_mask[i] &&
               ((chars[i] == CHAR_BITS'(ANY_ONE)) || (chars[i] == c));
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_wdata  = {end_of_text, adv};

endmodule
`default_nettype wire

>>> hw/rtl/wgm_queue.sv
`default_nettype none
module wgm_queue #(
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign rdata    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule
`default_nettype wire

>>> hw/rtl/wgm_back.sv
`default_nettype none
module wgm_back #(
  parameter int PATTERN_CHARS = wgm_pkg::PATTERN_CHARS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_nonempty,
  input  logic [PATTERN_CHARS:0]    q_rdata,
  output logic                      q_pop,
  input  logic [PATTERN_CHARS-1:0]  star_mask,
  input  logic [wgm_pkg::LEN_W-1:0] len_eff,
  input  logic                      rearm,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      matched
);
  import wgm_pkg::*;

  localparam int N      = PATTERN_CHARS;
  localparam int LEVELS = $clog2(N + 1);

  function automatic logic [N:0] closure(input logic [N:0] v, input logic [N-1:0] star);
    logic [N:0] g, p, g_o, p_o;
    int         s;
    g = v;
    p = {star, 1'b0};
    for (int l = 0; l < LEVELS; l++) begin
      g_o = g;
      p_o = p;
      s   = 1 << l;
      for (int i = 0; i <= N; i++) begin
        if (i >= s) begin
          g[i] = g_o[i] | (p_o[i] & g_o[i - s]);
          p[i] = p_o[i] & p_o[i - s];
        end else begin
          p[i] = 1'b0;
        end
      end
    end
    return g;
  endfunction

  logic [N:0]   live_r, start_vec, cur, nv, live_nxt;
  logic         fresh_r;
  logic         out_valid_r, matched_r, hit_bit;
  logic [N-1:0] adv;
  logic         last;
  logic         slot_free;

  assign adv       = q_rdata[N-1:0];
  assign last      = q_rdata[N];
  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = q_nonempty && (!last || slot_free);

  assign start_vec = closure({{N{1'b0}}, 1'b1}, star_mask);
  assign cur       = fresh_r ? start_vec : live_r;
  assign nv        = {1'b0, cur[N-1:0] & star_mask} | {cur[N-1:0] & adv, 1'b0};
  assign live_nxt  = closure(nv, star_mask);

  always_comb begin
    hit_bit = 1'b0;
    for (int i = 0; i <= N; i++) begin
      if (len_eff == LEN_W'(i)) hit_bit = live_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r     <= 1'b1;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rearm) begin
        fresh_r <= 1'b1;
      end else if (q_pop) begin
        fresh_r <= last;
        live_r  <= live_nxt;
      end
      if (q_pop && last) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && last) matched_r <= hit_bit;
  end

  assign out_valid = out_valid_r;
  assign matched   = matched_r;

endmodule
`default_nettype wire

>>> hw/rtl/wildcard_glob_matcher.sv
// Wildcard glob matcher: streams a text, one character per transaction, against a
// pattern of up to 16 characters held in configuration registers ('?' = any one
// character, '*' = any run, empty included).
// Input channel in_*: tdata carries the character, tlast marks its final one.
// Output channel out_*: one transaction per text, sent for the tlast character;
// out_tdata bit 0 is the match flag.
// Config port cfg_*: APB, 64-bit data, register i at byte address 8*i; pattern
// words 0..3 then the length. A write to any of them restarts the match.
// Throughput: one character per cycle while no held result stalls the back end,
// set by the combinational back-end live-position update (transition plus a
// log-depth star-closure tree). A tlast character's result passes the queue
// entry and then the output register to out_tvalid when the back end is free.
// A two-entry queue separates classification from the update; while out_tready is
// low the back end holds the pending result and stops only at the next tlast,
// and in_tready drops once the queue is full.
// Reset clears the registers to an empty pattern, empties the queue and the
// output register, and arms the start position.
`default_nettype none
module wildcard_glob_matcher #(
  parameter int PATTERN_CHARS = wgm_pkg::PATTERN_CHARS_DEF,
  parameter int CHAR_BITS     = wgm_pkg::CHAR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wgm_pkg::TEXT_W-1:0]       in_tdata,    // [15:0] text_char
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wgm_pkg::OUT_W-1:0]        out_tdata,   // [0] matched, [7:1] zero
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [wgm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [wgm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import wgm_pkg::*;

  logic [PATTERN_CHARS-1:0][CHAR_BITS-1:0] chars;
  logic [PATTERN_CHARS-1:0]                en_mask, star_mask;
  logic [LEN_W-1:0]                        len_eff;
  logic                                    rearm;
  logic                                    q_push, q_full, q_pop, q_nonempty;
  logic [PATTERN_CHARS:0]                  q_wdata, q_rdata;
  logic                                    matched;

  assign cfg_pready = 1'b1;

  wgm_cfg #(.PATTERN_CHARS(PATTERN_CHARS), .CHAR_BITS(CHAR_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .chars     (chars),
    .en_mask   (en_mask),
    .star_mask (star_mask),
    .len_eff   (len_eff),
    .rearm     (rearm)
  );

  wgm_front #(.PATTERN_CHARS(PATTERN_CHARS), .CHAR_BITS(CHAR_BITS)) u_front (
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .text_char   (in_tdata),
    .end_of_text (in_tlast),
    .chars       (chars),
    .en_mask     (en_mask),
    .star_mask   (star_mask),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  wgm_queue #(.WIDTH(PATTERN_CHARS + 1)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  wgm_back #(.PATTERN_CHARS(PATTERN_CHARS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .star_mask  (star_mask),
    .len_eff    (len_eff),
    .rearm      (rearm),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .matched    (matched)
  );

  assign out_tdata = {{(OUT_W-1){1'b0}}, matched};

endmodule
`default_nettype wire

>>> hw/rtl/wgm_checker.sv
`default_nettype none
module wgm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [wgm_pkg::OUT_W-1:0]      out_tdata,
  input logic                           cfg_pready
);
  import wgm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:1] == '0)
    else $error("output padding bits not zero");

  a_no_out_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_tready && cfg_pready)
    else $error("not ready right after reset");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

>>> tb/tb_wildcard_glob_matcher.sv
module tb_wildcard_glob_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] STAR_CHAR  = 16'(wgm_pkg::ANY_RUN);
  localparam logic [15:0] QMARK_CHAR = 16'(wgm_pkg::ANY_ONE);
  localparam int          CHAR_ITEMS = 1350;
  localparam int          HOLD_CYCLES = 300;

  class glob_match_scoreboard;
    logic [wgm_pkg::CFG_DATA_W-1:0] pat_word [wgm_pkg::PAT_WORDS];
    logic [wgm_pkg::LEN_W-1:0]      pat_len;
    logic [wgm_pkg::STORED_CHARS:0] live;
    bit                             match_due [$];
    int                             errors;

    function new();
      foreach (pat_word[k]) pat_word[k] = '0;
      pat_len = '0;
      errors  = 0;
      rearm();
    endfunction

    function void report(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    function int unsigned span();
      int unsigned n;
      n = pat_len;
      if (n > wgm_pkg::PATTERN_CHARS_DEF) n = wgm_pkg::PATTERN_CHARS_DEF;
      if (n > wgm_pkg::STORED_CHARS) n = wgm_pkg::STORED_CHARS;
      return n;
    endfunction

    function logic [15:0] pat_char(int unsigned i);
      return pat_word[i / wgm_pkg::CHARS_PER_WORD]
                     [(i % wgm_pkg::CHARS_PER_WORD) * wgm_pkg::PAT_CHAR_W +: 16];
    endfunction

    function logic [wgm_pkg::STORED_CHARS:0] close_stars(logic [wgm_pkg::STORED_CHARS:0] v);
      int unsigned n;
      n = span();
      for (int unsigned i = 0; i < n; i++)
        if (v[i] && pat_char(i) == STAR_CHAR) v[i + 1] = 1'b1;
      return v;
    endfunction

    function void rearm();
      live = close_stars((wgm_pkg::STORED_CHARS + 1)'(1));
    endfunction

    function int pending();
      return match_due.size();
    endfunction

    function void configure(logic [wgm_pkg::CFG_IDX_W-1:0] idx,
                            logic [wgm_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        wgm_pkg::REG_PAT0, wgm_pkg::REG_PAT1,
        wgm_pkg::REG_PAT2, wgm_pkg::REG_PAT3: pat_word[idx] = value;
        wgm_pkg::REG_LEN: pat_len = value[wgm_pkg::LEN_W-1:0];
        default: return;
      endcase
      rearm();
    endfunction

    function void note_char(logic [15:0] c, bit last);
      logic [wgm_pkg::STORED_CHARS:0] nxt;
      logic [15:0]                    p;
      int unsigned                    n;
      nxt = '0;
      n   = span();
      for (int unsigned i = 0; i < n; i++) begin
        if (live[i]) begin
          p = pat_char(i);
          if (p == STAR_CHAR) nxt[i] = 1'b1;
          else if (p == QMARK_CHAR || p == c) nxt[i + 1] = 1'b1;
        end
      end
      live = close_stars(nxt);
      if (last) begin
        match_due.push_back(live[n]);
        rearm();
      end
    endfunction

    function void check_result(logic [wgm_pkg::OUT_W-1:0] data);
      bit want;
      if (match_due.size() == 0) begin
        report($sformatf("unexpected result: expected none, actual matched=%0b", data[0]));
        return;
      end
      want = match_due.pop_front();
      if (data[0] !== want)
        report($sformatf("matched: expected %0b, actual %0b", want, data[0]));
      if (data[wgm_pkg::OUT_W-1:1] !== '0)
        report($sformatf("pad bits: expected 0, actual %0h", data[wgm_pkg::OUT_W-1:1]));
    endfunction

    function void report_leftover();
      if (match_due.size() != 0)
        report($sformatf("%0d results expected, actual none", match_due.size()));
    endfunction
  endclass

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [wgm_pkg::TEXT_W-1:0]      in_tdata    = '0;   // [15:0] text_char
  logic                            in_tlast    = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [wgm_pkg::OUT_W-1:0]       out_tdata;          // [0] matched, [7:1] zero
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [wgm_pkg::CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                            cfg_pready;

  glob_match_scoreboard sb = new;
  int          idle_pct     = 16;
  bit          hold_request = 1'b0;
  int          chars_sent   = 0;
  logic [15:0] text_buf [$];

  wildcard_glob_matcher u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic write_reg(logic [wgm_pkg::CFG_IDX_W-1:0] idx,
                           logic [wgm_pkg::CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= wgm_pkg::CFG_ADDR_W'(idx) << wgm_pkg::CFG_IDX_LSB;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.configure(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_char(logic [15:0] c, bit last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(16'(s[i]), i == s.len() - 1);
  endtask

  task automatic send_buf();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_pattern(string s, logic [wgm_pkg::CFG_DATA_W-1:0] len_val);
    logic [wgm_pkg::CFG_DATA_W-1:0] w [wgm_pkg::PAT_WORDS];
    foreach (w[k]) w[k] = '0;
    for (int i = 0; i < s.len() && i < wgm_pkg::STORED_CHARS; i++)
      w[i / 4][(i % 4) * 16 +: 16] = 16'(s[i]);
    for (int k = 0; k < wgm_pkg::PAT_WORDS; k++)
      write_reg(wgm_pkg::CFG_IDX_W'(wgm_pkg::REG_PAT0 + k), w[k]);
    write_reg(wgm_pkg::REG_LEN, len_val);
  endtask

  function automatic logic [15:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'h0061 + 16'($urandom_range(0, 2));
    if (r < 68) return STAR_CHAR;
    if (r < 74) return QMARK_CHAR;
    if (r < 80) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_pattern_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'h0061 + 16'($urandom_range(0, 2));
    if (r < 55) return STAR_CHAR;
    if (r < 70) return QMARK_CHAR;
    if (r < 80)
      return {8'($urandom_range(1, 255)),
              ($urandom_range(0, 1) != 0) ? wgm_pkg::ANY_RUN : wgm_pkg::ANY_ONE};
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic random_pattern();
    logic [wgm_pkg::CFG_DATA_W-1:0] w;
    logic [wgm_pkg::CFG_DATA_W-1:0] len_val;
    int unsigned                    r;
    int unsigned                    n;
    r = $urandom_range(0, 99);
    for (int k = 0; k < wgm_pkg::PAT_WORDS; k++) begin
      if (r < 5) w = '1;
      else if (r < 8) w = '0;
      else for (int j = 0; j < 4; j++) w[j * 16 +: 16] = pick_pattern_char();
      if (r < 8 || $urandom_range(0, 3) != 0)
        write_reg(wgm_pkg::CFG_IDX_W'(wgm_pkg::REG_PAT0 + k), w);
    end
    r = $urandom_range(0, 99);
    if (r < 60) n = $urandom_range(1, 8);
    else if (r < 75) n = $urandom_range(9, 16);
    else if (r < 85) n = 0;
    else n = $urandom_range(17, 31);
    len_val = {$urandom, $urandom};
    len_val[wgm_pkg::LEN_W-1:0] = wgm_pkg::LEN_W'(n);
    write_reg(wgm_pkg::REG_LEN, len_val);
  endtask

  function automatic void build_text(bit short_only);
    logic [15:0] p;
    int unsigned pos;
    text_buf.delete();
    if (short_only) begin
      text_buf.push_back(pick_char());
      if ($urandom_range(0, 2) == 0) text_buf.push_back(pick_char());
      return;
    end
    for (int unsigned i = 0; i < sb.span(); i++) begin
      p = sb.pat_char(i);
      if (p == STAR_CHAR) repeat ($urandom_range(0, 3)) text_buf.push_back(pick_char());
      else if (p == QMARK_CHAR) text_buf.push_back(pick_char());
      else text_buf.push_back(p);
    end
    if ($urandom_range(0, 99) < 30 && text_buf.size() > 0) begin
      pos = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 2))
        0:       text_buf[pos] = pick_char();
        1:       text_buf.insert(pos, pick_char());
        default: text_buf.delete(pos);
      endcase
    end
    if (text_buf.size() == 0) text_buf.push_back(pick_char());
  endfunction

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n_texts;
    bit short_only;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("a");
    settle();
    set_pattern("*", 1);
    send_text("abc");
    settle();
    set_pattern("a?c*", 4);
    send_text("abc");
    send_text("a*c?");
    send_text("abd");
    settle();
    set_pattern("ab", 2);
    send_text("xab");
    send_char(16'h0078, 1'b0);
    settle();
    // rearm in the middle of a text
    write_reg(wgm_pkg::REG_LEN, 1);
    send_text("a");
    settle();
    for (int k = 1; k <= 3; k++) write_reg(wgm_pkg::CFG_IDX_W'(wgm_pkg::REG_LEN + k), '1);
    send_text("b");
    settle();
    set_pattern("?", 1);
    send_char(16'hFFFF, 1'b1);
    send_char(16'h0000, 1'b1);
    send_text("*");
    settle();
    set_pattern("****************", 31);
    send_text("q");
    settle();
    set_pattern("abc", 0);
    send_text("a");
    settle();

    phase = 0;
    while (chars_sent < CHAR_ITEMS) begin
      phase++;
      idle_pct   = (phase % 6 == 2) ? 0 : 16;
      short_only = (phase == 4);
      random_pattern();
      if (short_only) hold_request = 1'b1;
      n_texts = short_only ? 40 : $urandom_range(4, 12);
      repeat (n_texts) begin
        build_text(short_only);
        send_buf();
      end
      settle();
    end

    repeat (12) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/wgm_pkg.sv
hw/rtl/wgm_cfg.sv
hw/rtl/wgm_front.sv
hw/rtl/wgm_queue.sv
hw/rtl/wgm_back.sv
hw/rtl/wildcard_glob_matcher.sv
hw/rtl/wgm_checker.sv
tb/tb_wildcard_glob_matcher.sv
